### rtl/core/tss_pkg.sv
`timescale 1ns / 1ps

package tss_pkg;

  localparam int NUM_TASKS = 64;
  localparam int SLOT_W    = 6;
  localparam int IDX_W     = SLOT_W + 1;
  localparam int PID_W     = 31;
  localparam int CH_W      = 32;

  // Seven-bit slot code that means "no slot".
  localparam logic [IDX_W-1:0] NO_SLOT = IDX_W'(NUM_TASKS);

  typedef enum logic [2:0] {
    OP_CREATE   = 3'd0,
    OP_DISPATCH = 3'd1,
    OP_YIELD    = 3'd2,
    OP_SLEEP    = 3'd3,
    OP_WAKEUP   = 3'd4,
    OP_KILL     = 3'd5,
    OP_EXIT     = 3'd6,
    OP_WAIT     = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_EMPTY     = 3'd1,
    STS_NOT_FOUND = 3'd2,
    STS_NO_KIDS   = 3'd3,
    STS_SLEPT     = 3'd4,
    STS_NO_CUR    = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    TS_UNUSED   = 3'd0,
    TS_RUNNABLE = 3'd1,
    TS_RUNNING  = 3'd2,
    TS_SLEEPING = 3'd3,
    TS_ZOMBIE   = 3'd4
  } tstat_e;

  typedef enum logic [1:0] {
    RS_IDX,
    RS_CUR,
    RS_SLOT,
    RS_HEAD
  } rdsrc_e;

  typedef enum logic [3:0] {
    EV_NONE,
    EV_CREATE,
    EV_DISP_CUR,
    EV_DISP,
    EV_YIELD,
    EV_SLEEP,
    EV_EXIT_HD,
    EV_WAKE,
    EV_KILL,
    EV_EXIT,
    EV_WAIT,
    EV_EXIT_FIN,
    EV_WAIT_FIN
  } ev_e;

  typedef struct packed {
    tstat_e             status;
    logic [PID_W-1:0]   ident;
    logic [IDX_W-1:0]   parent;
    logic [CH_W-1:0]    channel;
    logic               killed;
  } row_t;

  localparam row_t ROW_RESET = '{
    status:  TS_UNUSED,
    ident:   '0,
    parent:  NO_SLOT,
    channel: '0,
    killed:  1'b0
  };

  typedef struct packed {
    logic              latch;
    logic              clr;
    logic              rd_en;
    rdsrc_e            rd_src;
    logic [SLOT_W-1:0] rd_idx;
    logic              link_rd;
    ev_e               ev;
    logic              wch_item;
    logic              wch_init;
    logic              set_sts;
    status_e           sts;
    logic              out_load;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic have_cur;
    logic cur_init;
    logic queue_empty;
    logic hit;
    logic found;
    logic kids;
    logic zomb;
  } dp_sts_t;

endpackage

### rtl/core/tss_dp.sv
`timescale 1ns / 1ps

module tss_dp import tss_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [2:0]        operation_i,
  input  logic [SLOT_W-1:0] slot_i,
  input  logic [PID_W-1:0]  task_pid_i,
  input  logic [SLOT_W-1:0] parent_slot_i,
  input  logic [CH_W-1:0]   channel_i,
  input  logic [SLOT_W-1:0] init_i,
  input  dp_cmd_t           cmd_i,
  output dp_sts_t           sts_o,
  output logic [2:0]        status_o,
  output logic [SLOT_W-1:0] result_slot_o,
  output logic [PID_W-1:0]  result_pid_o
);

  // Latched word.
  op_e               op_q;
  logic [SLOT_W-1:0] slot_q, par_q;
  logic [PID_W-1:0]  pid_q;
  logic [CH_W-1:0]   ch_q;

  // Task table and run queue.
  row_t              row_mem [NUM_TASKS];
  logic [SLOT_W-1:0] link_mem [NUM_TASKS];
  logic [NUM_TASKS-1:0] vld_q;
  row_t              rd_row_q;
  logic              rd_vld_q;
  logic [SLOT_W-1:0] raddr_q;
  logic [SLOT_W-1:0] link_q;
  logic [SLOT_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [IDX_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  run_q, run_d;

  // Scan context and result.
  logic [CH_W-1:0]   wch_q, wch_d;
  logic              wake_en_q, wake_en_d;
  logic              found_q, found_d, kids_q, kids_d, zomb_q, zomb_d;
  status_e           res_sts_q, res_sts_d, out_sts_q;
  logic [SLOT_W-1:0] res_slot_q, res_slot_d, out_slot_q;
  logic [PID_W-1:0]  res_pid_q, res_pid_d, out_pid_q;

  row_t              row, wr_row;
  logic              wr_en, push, pop, clr_vld, hit, wake_m, child;
  logic [SLOT_W-1:0] s, ra, cur;

  assign cur = run_q[SLOT_W-1:0];
  assign s   = raddr_q;
  assign row = rd_vld_q ? rd_row_q : ROW_RESET;

  always_comb begin
    unique case (cmd_i.rd_src)
      RS_IDX:  ra = cmd_i.rd_idx;
      RS_CUR:  ra = cur;
      RS_SLOT: ra = slot_q;
      RS_HEAD: ra = head_q;
      default: ra = cmd_i.rd_idx;
    endcase
  end

  assign wake_m = wake_en_q && (row.status == TS_SLEEPING) && (row.channel == wch_q);
  assign child  = (row.parent == {1'b0, cur});

  always_comb begin
    wr_en      = 1'b0;
    wr_row     = row;
    push       = 1'b0;
    pop        = 1'b0;
    clr_vld    = 1'b0;
    hit        = 1'b0;
    run_d      = run_q;
    wch_d      = wch_q;
    wake_en_d  = wake_en_q;
    found_d    = found_q;
    kids_d     = kids_q;
    zomb_d     = zomb_q;
    res_sts_d  = res_sts_q;
    res_slot_d = res_slot_q;
    res_pid_d  = res_pid_q;
    case (cmd_i.ev)
      EV_CREATE: begin
        if (row.status == TS_UNUSED) begin
          wr_row = '{status: TS_RUNNABLE, ident: pid_q, parent: {1'b0, par_q},
                     channel: '0, killed: 1'b0};
          wr_en  = 1'b1;
          push   = 1'b1;
        end
      end
      EV_DISP_CUR: begin
        res_slot_d = s;
        res_pid_d  = row.ident;
      end
      EV_DISP: begin
        pop            = 1'b1;
        wr_row.status  = TS_RUNNING;
        wr_row.channel = '0;
        wr_en          = 1'b1;
        run_d          = {1'b0, s};
        res_slot_d     = s;
        res_pid_d      = row.ident;
      end
      EV_YIELD: begin
        wr_row.status = TS_RUNNABLE;
        wr_en         = 1'b1;
        push          = 1'b1;
        run_d         = NO_SLOT;
      end
      EV_SLEEP: begin
        wr_row.status  = TS_SLEEPING;
        wr_row.channel = ch_q;
        wr_en          = 1'b1;
        run_d          = NO_SLOT;
      end
      EV_EXIT_HD: begin
        wch_d     = {{(CH_W-IDX_W){1'b0}}, row.parent};
        wake_en_d = !row.parent[IDX_W-1];
      end
      EV_WAKE: begin
        if (wake_m) begin
          wr_row.status = TS_RUNNABLE;
          wr_en         = 1'b1;
          push          = 1'b1;
        end
      end
      EV_KILL: begin
        if (row.ident == pid_q) begin
          wr_row.killed = 1'b1;
          wr_en         = 1'b1;
          hit           = 1'b1;
          found_d       = 1'b1;
          if (row.status == TS_SLEEPING) begin
            wr_row.status = TS_RUNNABLE;
            push          = 1'b1;
          end
        end
      end
      EV_EXIT: begin
        if (wake_m) begin
          wr_row.status = TS_RUNNABLE;
          wr_en         = 1'b1;
          push          = 1'b1;
        end
        if (child) begin
          wr_row.parent = {1'b0, init_i};
          wr_en         = 1'b1;
          if (row.status == TS_ZOMBIE) zomb_d = 1'b1;
        end
      end
      EV_WAIT: begin
        if (child) begin
          kids_d = 1'b1;
          if (row.status == TS_ZOMBIE) begin
            res_slot_d = s;
            res_pid_d  = row.ident;
            clr_vld    = 1'b1;
            hit        = 1'b1;
            found_d    = 1'b1;
          end
        end
      end
      EV_EXIT_FIN: begin
        wr_row.status = TS_ZOMBIE;
        wr_en         = 1'b1;
        run_d         = NO_SLOT;
      end
      EV_WAIT_FIN: begin
        if (row.killed) begin
          res_sts_d = STS_NO_KIDS;
        end else begin
          wr_row.status  = TS_SLEEPING;
          wr_row.channel = {{(CH_W-SLOT_W){1'b0}}, s};
          wr_en          = 1'b1;
          run_d          = NO_SLOT;
          res_sts_d      = STS_SLEPT;
        end
      end
      default: ;
    endcase
    if (cmd_i.clr) begin
      found_d    = 1'b0;
      kids_d     = 1'b0;
      zomb_d     = 1'b0;
      res_sts_d  = STS_OK;
      res_slot_d = '0;
      res_pid_d  = '0;
    end
    if (cmd_i.set_sts) res_sts_d = cmd_i.sts;
    if (cmd_i.wch_item) begin
      wch_d     = ch_q;
      wake_en_d = 1'b1;
    end
    if (cmd_i.wch_init) begin
      wch_d     = {{(CH_W-SLOT_W){1'b0}}, init_i};
      wake_en_d = 1'b1;
    end
  end

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (push) begin
      if (count_q == '0) head_d = s;
      tail_d  = s;
      count_d = count_q + IDX_W'(1);
    end else if (pop) begin
      count_d = count_q - IDX_W'(1);
      if (count_q > IDX_W'(1)) head_d = link_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) row_mem[s] <= wr_row;
    if (cmd_i.rd_en) begin
      rd_row_q <= row_mem[ra];
      rd_vld_q <= vld_q[ra];
      raddr_q  <= ra;
    end
    if (push && (count_q != '0)) link_mem[tail_q] <= s;
    if (cmd_i.link_rd) link_q <= link_mem[head_q];
    if (cmd_i.latch) begin
      op_q   <= op_e'(operation_i);
      slot_q <= slot_i;
      pid_q  <= task_pid_i;
      par_q  <= parent_slot_i;
      ch_q   <= channel_i;
    end
    wch_q      <= wch_d;
    res_slot_q <= res_slot_d;
    res_pid_q  <= res_pid_d;
    if (cmd_i.out_load) begin
      out_sts_q  <= res_sts_q;
      out_slot_q <= res_slot_q;
      out_pid_q  <= res_pid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      run_q     <= NO_SLOT;
      wake_en_q <= 1'b0;
      found_q   <= 1'b0;
      kids_q    <= 1'b0;
      zomb_q    <= 1'b0;
      res_sts_q <= STS_OK;
    end else begin
      if (wr_en) vld_q[s] <= 1'b1;
      if (clr_vld) vld_q[s] <= 1'b0;
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      run_q     <= run_d;
      wake_en_q <= wake_en_d;
      found_q   <= found_d;
      kids_q    <= kids_d;
      zomb_q    <= zomb_d;
      res_sts_q <= res_sts_d;
    end
  end

  assign sts_o = '{
    op:          op_q,
    have_cur:    !run_q[IDX_W-1],
    cur_init:    (cur == init_i),
    queue_empty: (count_q == '0),
    hit:         hit,
    found:       found_q,
    kids:        kids_q,
    zomb:        zomb_q
  };

  assign status_o      = out_sts_q;
  assign result_slot_o = out_slot_q;
  assign result_pid_o  = out_pid_q;

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (count_q != '0))
    else $error("run queue popped while empty");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (count_q < IDX_W'(NUM_TASKS)))
    else $error("run queue pushed while full");
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && cmd_i.rd_en) |-> (s != ra))
    else $error("task row read and written at the same slot");
`endif

endmodule

### rtl/core/tss_ctrl.sv
`timescale 1ns / 1ps

module tss_ctrl import tss_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_EVAL,
    S_SCAN,
    S_POST,
    S_DONE
  } state_e;

  state_e           state_q, state_d;
  ev_e              ev_q, ev_d, mode_q, mode_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             p2_q, p2_d;
  logic             out_valid_q, out_valid_d;
  logic             scan_last;

  assign scan_last = (cnt_q == IDX_W'(NUM_TASKS));

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    ev_d        = ev_q;
    mode_d      = mode_q;
    cnt_d       = cnt_q;
    p2_d        = p2_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        cmd_o.latch = in_valid_i;
        if (in_valid_i) state_d = S_DEC;
      end
      S_DEC: begin
        cmd_o.clr = 1'b1;
        p2_d      = 1'b0;
        cnt_d     = '0;
        state_d   = S_DONE;
        unique case (sts_i.op)
          OP_CREATE: begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_src = RS_SLOT;
            ev_d         = EV_CREATE;
            state_d      = S_EVAL;
          end
          OP_DISPATCH: begin
            if (sts_i.have_cur) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_src = RS_CUR;
              ev_d         = EV_DISP_CUR;
              state_d      = S_EVAL;
            end else if (sts_i.queue_empty) begin
              cmd_o.set_sts = 1'b1;
              cmd_o.sts     = STS_EMPTY;
            end else begin
              cmd_o.rd_en   = 1'b1;
              cmd_o.rd_src  = RS_HEAD;
              cmd_o.link_rd = 1'b1;
              ev_d          = EV_DISP;
              state_d       = S_EVAL;
            end
          end
          OP_WAKEUP: begin
            cmd_o.wch_item = 1'b1;
            mode_d         = EV_WAKE;
            state_d        = S_SCAN;
          end
          OP_KILL: begin
            mode_d  = EV_KILL;
            state_d = S_SCAN;
          end
          default: begin
            // Yield, sleep, exit and wait all act on the running task.
            if (!sts_i.have_cur) begin
              cmd_o.set_sts = 1'b1;
              cmd_o.sts     = STS_NO_CUR;
            end else if (sts_i.op == OP_WAIT) begin
              mode_d  = EV_WAIT;
              state_d = S_SCAN;
            end else if (sts_i.op == OP_EXIT && sts_i.cur_init) begin
              state_d = S_DONE;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_src = RS_CUR;
              state_d      = S_EVAL;
              if (sts_i.op == OP_YIELD) ev_d = EV_YIELD;
              else if (sts_i.op == OP_SLEEP) ev_d = EV_SLEEP;
              else ev_d = EV_EXIT_HD;
            end
          end
        endcase
      end
      S_EVAL: begin
        cmd_o.ev = ev_q;
        if (ev_q == EV_EXIT_HD) begin
          mode_d  = EV_EXIT;
          cnt_d   = '0;
          state_d = S_SCAN;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SCAN: begin
        // Reads run one slot ahead of the evaluation of the previous slot.
        cmd_o.rd_en  = !scan_last;
        cmd_o.rd_src = RS_IDX;
        cmd_o.rd_idx = cnt_q[SLOT_W-1:0];
        cmd_o.ev     = (cnt_q != '0) ? mode_q : EV_NONE;
        cnt_d        = cnt_q + IDX_W'(1);
        if (scan_last || ((cnt_q != '0) && sts_i.hit)) state_d = S_POST;
      end
      S_POST: begin
        state_d = S_DONE;
        case (mode_q)
          EV_WAKE: begin
            if (p2_q) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_src = RS_CUR;
              ev_d         = EV_EXIT_FIN;
              state_d      = S_EVAL;
            end
          end
          EV_KILL: begin
            if (!sts_i.found) begin
              cmd_o.set_sts = 1'b1;
              cmd_o.sts     = STS_NOT_FOUND;
            end
          end
          EV_EXIT: begin
            if (sts_i.zomb) begin
              // A zombie went to init: init may be waiting for it.
              cmd_o.wch_init = 1'b1;
              p2_d           = 1'b1;
              mode_d         = EV_WAKE;
              cnt_d          = '0;
              state_d        = S_SCAN;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_src = RS_CUR;
              ev_d         = EV_EXIT_FIN;
              state_d      = S_EVAL;
            end
          end
          EV_WAIT: begin
            if (!sts_i.found) begin
              if (sts_i.kids) begin
                cmd_o.rd_en  = 1'b1;
                cmd_o.rd_src = RS_CUR;
                ev_d         = EV_WAIT_FIN;
                state_d      = S_EVAL;
              end else begin
                cmd_o.set_sts = 1'b1;
                cmd_o.sts     = STS_NO_KIDS;
              end
            end
          end
          default: ;
        endcase
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ev_q        <= EV_NONE;
      mode_q      <= EV_NONE;
      cnt_q       <= '0;
      p2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ev_q        <= ev_d;
      mode_q      <= mode_d;
      cnt_q       <= cnt_d;
      p2_q        <= p2_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DEC))
    else $error("accepted word not decoded next cycle");
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (cnt_q <= IDX_W'(NUM_TASKS)))
    else $error("scan index ran past the table");
  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_o)
    else $error("result loaded without valid");
`endif

endmodule

### rtl/core/task_state_scheduler.sv
`timescale 1ns / 1ps
// Create, dispatch, yield and sleep each read one table row. Dispatch on an empty queue,
// exit by init, and yield, sleep, exit or wait with no running task finish without a read.
// Wakeup, kill and wait scan the 64-entry table one slot per cycle; kill and wait end on a hit.
// Exit makes one or two scans. A stalled result holds the word until the receiver is ready.
// One word is in work at a time; the next is accepted the cycle after the result is loaded.
// Reset is asynchronous, active low: all slots unused, queue empty, no task running.

module task_state_scheduler import tss_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        operation_i,
  input  logic [SLOT_W-1:0] slot_i,
  input  logic [PID_W-1:0]  task_pid_i,
  input  logic [SLOT_W-1:0] parent_slot_i,
  input  logic [CH_W-1:0]   channel_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        status_o,
  output logic [SLOT_W-1:0] result_slot_o,
  output logic [PID_W-1:0]  result_pid_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [SLOT_W-1:0] init_q;
  dp_cmd_t           cmd;
  dp_sts_t           sts;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32-SLOT_W){1'b0}}, init_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      init_q <= pwdata[SLOT_W-1:0];
    end
  end

  tss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tss_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .operation_i   (operation_i),
    .slot_i        (slot_i),
    .task_pid_i    (task_pid_i),
    .parent_slot_i (parent_slot_i),
    .channel_i     (channel_i),
    .init_i        (init_q),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .status_o      (status_o),
    .result_slot_o (result_slot_o),
    .result_pid_o  (result_pid_o)
  );

endmodule

### tb/task_state_scheduler_tb.sv
`timescale 1ns / 1ps

class sched_scoreboard;
  typedef struct {
    logic [2:0]        status;
    logic [5:0]        rslot;
    logic [30:0]       rpid;
  } outcome_t;

  // Shadow copy of the task table and run queue.
  logic [2:0]  st [64];
  logic [30:0] ident [64];
  logic [6:0]  parent [64];
  logic [31:0] chan [64];
  logic        killed [64];
  logic [5:0]  link [64];
  logic [5:0]  head, tail;
  int          count;
  logic [6:0]  running;
  logic [5:0]  init_slot;
  outcome_t    pending[$];
  int          errors;
  int          checked;

  function new();
    for (int i = 0; i < 64; i++) begin
      st[i] = tss_pkg::TS_UNUSED;
      ident[i] = '0;
      parent[i] = tss_pkg::NO_SLOT;
      chan[i] = '0;
      killed[i] = 1'b0;
      link[i] = '0;
    end
    head = '0;
    tail = '0;
    count = 0;
    running = tss_pkg::NO_SLOT;
    init_slot = '0;
    errors = 0;
    checked = 0;
  endfunction

  function void enqueue(int s);
    st[s] = tss_pkg::TS_RUNNABLE;
    if (count == 0) head = s[5:0];
    else link[tail] = s[5:0];
    tail = s[5:0];
    count++;
  endfunction

  function void wake(logic [31:0] ch);
    for (int i = 0; i < 64; i++)
      if (st[i] == tss_pkg::TS_SLEEPING && chan[i] == ch) enqueue(i);
  endfunction

  function void note_word(logic [2:0] op, logic [5:0] slot, logic [30:0] pid,
                          logic [5:0] par, logic [31:0] ch);
    outcome_t o;
    int cur;
    logic have_cur;
    logic kids, reaped;
    logic [6:0] adopt;
    o.status = tss_pkg::STS_OK;
    o.rslot = '0;
    o.rpid = '0;
    cur = running;
    have_cur = running < 64;
    if (op != tss_pkg::OP_CREATE && op != tss_pkg::OP_DISPATCH &&
        op != tss_pkg::OP_WAKEUP && op != tss_pkg::OP_KILL && !have_cur) begin
      o.status = tss_pkg::STS_NO_CUR;
    end else begin
      case (op)
        tss_pkg::OP_CREATE: begin
          if (st[slot] == tss_pkg::TS_UNUSED) begin
            ident[slot] = pid;
            parent[slot] = {1'b0, par};
            chan[slot] = '0;
            killed[slot] = 1'b0;
            enqueue(slot);
          end
        end
        tss_pkg::OP_DISPATCH: begin
          if (have_cur) begin
            o.rslot = cur[5:0];
            o.rpid = ident[cur];
          end else if (count == 0) begin
            o.status = tss_pkg::STS_EMPTY;
          end else begin
            int s;
            s = head;
            count--;
            if (count > 0) head = link[s];
            st[s] = tss_pkg::TS_RUNNING;
            chan[s] = '0;
            running = s[6:0];
            o.rslot = s[5:0];
            o.rpid = ident[s];
          end
        end
        tss_pkg::OP_YIELD: begin
          enqueue(cur);
          running = tss_pkg::NO_SLOT;
        end
        tss_pkg::OP_SLEEP: begin
          chan[cur] = ch;
          st[cur] = tss_pkg::TS_SLEEPING;
          running = tss_pkg::NO_SLOT;
        end
        tss_pkg::OP_WAKEUP: wake(ch);
        tss_pkg::OP_KILL: begin
          o.status = tss_pkg::STS_NOT_FOUND;
          for (int i = 0; i < 64; i++) begin
            if (ident[i] == pid) begin
              killed[i] = 1'b1;
              if (st[i] == tss_pkg::TS_SLEEPING) enqueue(i);
              o.status = tss_pkg::STS_OK;
              break;
            end
          end
        end
        tss_pkg::OP_EXIT: begin
          if (cur != init_slot) begin
            adopt = {1'b0, init_slot};
            if (parent[cur] < 64) wake({25'd0, parent[cur]});
            for (int i = 0; i < 64; i++) begin
              if (parent[i] == cur) begin
                parent[i] = adopt;
                if (st[i] == tss_pkg::TS_ZOMBIE) wake({25'd0, adopt});
              end
            end
            st[cur] = tss_pkg::TS_ZOMBIE;
            running = tss_pkg::NO_SLOT;
          end
        end
        default: begin
          kids = 1'b0;
          reaped = 1'b0;
          for (int i = 0; i < 64; i++) begin
            if (parent[i] != cur) continue;
            kids = 1'b1;
            if (st[i] == tss_pkg::TS_ZOMBIE) begin
              o.rslot = i[5:0];
              o.rpid = ident[i];
              ident[i] = '0;
              parent[i] = tss_pkg::NO_SLOT;
              chan[i] = '0;
              killed[i] = 1'b0;
              st[i] = tss_pkg::TS_UNUSED;
              reaped = 1'b1;
              break;
            end
          end
          if (!reaped) begin
            if (!kids || killed[cur]) begin
              o.status = tss_pkg::STS_NO_KIDS;
            end else begin
              chan[cur] = cur;
              st[cur] = tss_pkg::TS_SLEEPING;
              running = tss_pkg::NO_SLOT;
              o.status = tss_pkg::STS_SLEPT;
            end
          end
        end
      endcase
    end
    pending.push_back(o);
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  task automatic check_word(logic [2:0] status, logic [5:0] rslot, logic [30:0] rpid);
    outcome_t o;
    if (pending.size() == 0) begin
      report("unexpected word", 32'd1, 32'd0);
      return;
    end
    o = pending.pop_front();
    checked++;
    if (status !== o.status) report("status", status, o.status);
    if (rslot !== o.rslot) report("result_slot", rslot, o.rslot);
    if (rpid !== o.rpid) report("result_pid", rpid, o.rpid);
  endtask
endclass

module task_state_scheduler_tb;
  import tss_pkg::*;

  localparam int WATCHDOG = 20000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [2:0]        operation_i = '0;
  logic [SLOT_W-1:0] slot_i = '0;
  logic [PID_W-1:0]  task_pid_i = '0;
  logic [SLOT_W-1:0] parent_slot_i = '0;
  logic [CH_W-1:0]   channel_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [2:0]        status_o;
  logic [SLOT_W-1:0] result_slot_o;
  logic [PID_W-1:0]  result_pid_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  sched_scoreboard board;
  bit  sink_idles = 1'b0;
  bit  long_hold = 1'b0;
  int  quiet_cycles = 0;
  int  words_sent = 0;
  logic [30:0] pid_pool [8];

  always #5 clk_i = ~clk_i;

  task_state_scheduler uut (.*);

  // Watchdog on accepted traffic, and checking of results at the rising edge.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG) begin
      $display("watchdog expired");
      $display("*** FAILED ***");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_word(status_o, result_slot_o, result_pid_o);
  end

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_ready_i <= 1'b0;
        repeat (400) @(negedge clk_i);
        long_hold = 1'b0;
        out_ready_i <= 1'b1;
      end else if (sink_idles && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 12);
        out_ready_i <= 1'b0;
        repeat (n) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic write_init(logic [5:0] v);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= {26'd0, v};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    board.init_slot = v;
  endtask

  task automatic send_word(logic [2:0] op, logic [5:0] slot, logic [30:0] pid,
                           logic [5:0] par, logic [31:0] ch, bit gaps);
    if (gaps && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op; slot_i <= slot; task_pid_i <= pid;
    parent_slot_i <= par; channel_i <= ch;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_word(op, slot, pid, par, ch);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
  endtask

  // Random word biased toward a lively task system: small pid pool,
  // channels mostly slot numbers so wait and exit wakeups connect.
  task automatic random_word(bit gaps);
    logic [2:0]  op;
    logic [31:0] ch;
    logic [30:0] pid;
    int r;
    r = $urandom_range(0, 99);
    if (r < 18) op = OP_CREATE;
    else if (r < 40) op = OP_DISPATCH;
    else if (r < 50) op = OP_YIELD;
    else if (r < 58) op = OP_SLEEP;
    else if (r < 66) op = OP_WAKEUP;
    else if (r < 73) op = OP_KILL;
    else if (r < 87) op = OP_EXIT;
    else op = OP_WAIT;
    ch = ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(0, 63));
    pid = ($urandom_range(0, 4) == 0) ? 31'($urandom()) : pid_pool[$urandom_range(0, 7)];
    send_word(op, 6'($urandom_range(0, 63)), pid, 6'($urandom_range(0, 63)), ch, gaps);
  endtask

  initial begin
    board = new();
    for (int i = 0; i < 8; i++) pid_pool[i] = 31'($urandom());
    pid_pool[0] = '1;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    write_init(6'd0);

    // Directed: empty queue, no running task, extremes, and each corner case.
    send_word(OP_DISPATCH, 0, 0, 0, 0, 0);
    send_word(OP_YIELD, 0, 0, 0, 0, 0);
    send_word(OP_SLEEP, 0, 0, 0, 0, 0);
    send_word(OP_EXIT, 0, 0, 0, 0, 0);
    send_word(OP_WAIT, 0, 0, 0, 0, 0);
    send_word(OP_KILL, 0, 31'h7fffffff, 0, 0, 0);
    send_word(OP_CREATE, 6'd0, 31'd1, 6'd63, 0, 0);
    send_word(OP_CREATE, 6'd0, 31'd9, 6'd5, 0, 0);
    send_word(OP_CREATE, 6'd63, 31'h7fffffff, 6'd0, 0, 0);
    send_word(OP_CREATE, 6'd5, 31'd5, 6'd0, 0, 0);
    send_word(OP_DISPATCH, 0, 0, 0, 0, 0);
    send_word(OP_DISPATCH, 0, 0, 0, 0, 0);
    send_word(OP_WAIT, 0, 0, 0, 0, 0);
    send_word(OP_DISPATCH, 0, 0, 0, 0, 0);
    send_word(OP_SLEEP, 0, 0, 0, 32'hffffffff, 0);
    send_word(OP_KILL, 0, 31'd1, 0, 0, 0);
    send_word(OP_WAKEUP, 0, 0, 0, 32'hffffffff, 0);
    send_word(OP_DISPATCH, 0, 0, 0, 0, 0);
    send_word(OP_EXIT, 0, 0, 0, 0, 0);
    send_word(OP_DISPATCH, 0, 0, 0, 0, 0);
    send_word(OP_WAIT, 0, 0, 0, 0, 0);
    send_word(OP_YIELD, 0, 0, 0, 0, 0);
    send_word(OP_DISPATCH, 0, 0, 0, 0, 0);
    send_word(OP_EXIT, 0, 0, 0, 0, 0);
    drain();

    // Random phases with different init slots, extremes included.
    sink_idles = 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_init(6'd63);
        1: write_init(6'($urandom_range(1, 62)));
        2: write_init(6'd0);
        default: write_init(6'd1);
      endcase
      if (ph == 3) sink_idles = 1'b0;
      for (int k = 0; k < 115; k++) begin
        if (ph == 1 && k == 20) long_hold = 1'b1;
        random_word(ph != 3);
      end
      drain();
    end

    $display("Sent %0d words, checked %0d results across four init settings,",
             words_sent, board.checked);
    $display("including a long receiver hold-off and random idling on both sides.");
    if (board.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

### filelist.f
rtl/core/tss_pkg.sv
rtl/core/tss_dp.sv
rtl/core/tss_ctrl.sv
rtl/core/task_state_scheduler.sv
tb/task_state_scheduler_tb.sv
